### hdl/rtw_pkg.sv
// Shared constants and types for the retransmit timer wheel.
// Holds the wheel geometry, field widths, opcodes and the entry record kept in RAM.
// Depends on nothing.
package rtw_pkg;

    // The bucket count is a power of two so that every mod is a bit slice.
    localparam int BUCKET_BITS  = 6;
    localparam int BUCKETS      = 1 << BUCKET_BITS;
    localparam int LIMIT_BITS   = BUCKET_BITS + 1;
    localparam int ENTRIES      = 32;
    localparam int ENTRY_BITS   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ORDER_BITS   = 16;
    localparam int OPC_BITS     = 2;
    localparam int ID_BITS      = 5;
    localparam int TIMEOUT_BITS = 6;
    localparam int TIME_BITS    = 32;

    localparam logic [OPC_BITS-1:0] OP_ARM     = 2'd0;
    localparam logic [OPC_BITS-1:0] OP_CANCEL  = 2'd1;
    localparam logic [OPC_BITS-1:0] OP_ADVANCE = 2'd2;

    localparam logic KIND_EXPIRED  = 1'b0;
    localparam logic KIND_FINISHED = 1'b1;

    typedef logic [BUCKET_BITS-1:0] bucket_t;
    typedef logic [ORDER_BITS-1:0]  order_t;
    typedef logic [ENTRY_BITS-1:0]  entry_idx_t;

    typedef struct packed {
        bucket_t bucket;
        order_t  order;
    } entry_rec_t;

endpackage

### hdl/rtw_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Used for the per-entry timer records. Depends on nothing.
module rtw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]                              wr_data,
    input  logic                                          rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
    output logic [WIDTH-1:0]                              rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/retransmit_timer_wheel_core.sv
// An item with no elapsed ticks goes from idle to the finish state, which loads its finished
// beat once the output is free. With elapsed ticks, each selection pass reads every entry
// record once (32-entry RAM read at one record a cycle), one pass per expiry plus a final
// empty pass. One item at a time: the next is taken the cycle after the finished beat is
// loaded, even while that beat waits downstream. Reset clears armed flags, insert count and
// last time.
module retransmit_timer_wheel_core
    import rtw_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  logic [OPC_BITS-1:0]     opcode,
    input  logic [ID_BITS-1:0]      entry_id,
    input  logic [TIMEOUT_BITS-1:0] timeout,
    input  logic [TIME_BITS-1:0]    now_time,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic                    kind,
    output logic [ID_BITS-1:0]      expired_id,
    output logic                    last
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_EMIT   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    localparam entry_idx_t LAST_ENTRY = ENTRY_BITS'(ENTRIES - 1);

    logic [1:0]             state_reg;
    logic [ENTRIES-1:0]     armed_reg;
    order_t                 insert_count_reg;
    logic [TIME_BITS-1:0]   last_time_reg;
    logic                   issue_on_reg;
    entry_idx_t             issue_addr_reg;
    logic                   chk_valid_reg;
    entry_idx_t             chk_addr_reg;
    logic                   found_reg;
    logic                   result_valid_reg;

    logic [OPC_BITS-1:0]    op_reg;
    entry_idx_t             id_reg;
    logic                   id_ok_reg;
    bucket_t                arm_bucket_reg;
    bucket_t                base_reg;
    logic [LIMIT_BITS-1:0]  limit_reg;
    entry_idx_t             best_id_reg;
    bucket_t                best_dist_reg;
    order_t                 best_age_reg;
    logic                   kind_reg;
    logic [ID_BITS-1:0]     expired_id_reg;
    logic                   last_reg;

    logic                   item_accept;
    logic                   out_free;
    logic [TIME_BITS-1:0]   ticks;
    logic [LIMIT_BITS-1:0]  limit_next;
    entry_rec_t             rd_rec;
    bucket_t                bucket_gap;
    order_t                 age;
    logic                   cand;
    logic                   emit_load;
    logic                   fin_load;
    logic                   do_arm;
    logic                   do_cancel;
    logic                   pass_done;

    assign item_stall  = (state_reg != S_IDLE);
    assign item_accept = item_valid && !item_stall;
    assign out_free    = !result_valid_reg || !result_stall;

    always_comb
    begin
        ticks = (now_time >= last_time_reg) ? (now_time - last_time_reg) : '0;
        if (ticks > TIME_BITS'(BUCKETS))
        begin
            limit_next = LIMIT_BITS'(BUCKETS);
        end
        else
        begin
            limit_next = ticks[LIMIT_BITS-1:0];
        end
    end

    rtw_ram #(
        .WIDTH($bits(entry_rec_t)),
        .DEPTH(ENTRIES)
    ) u_rec_ram (
        .clk     (clk),
        .wr_en   (fin_load && do_arm),
        .wr_addr (id_reg),
        .wr_data ({arm_bucket_reg, insert_count_reg}),
        .rd_en   ((state_reg == S_SCAN) && issue_on_reg),
        .rd_addr (issue_addr_reg),
        .rd_data (rd_rec)
    );

    // An entry is a candidate if its bucket falls inside the visited window. Ordering is by
    // distance from the starting bucket, then by age (oldest first), then by lower id.
    always_comb
    begin
        bucket_gap = rd_rec.bucket - base_reg;
        age        = insert_count_reg - rd_rec.order;
        cand = chk_valid_reg && armed_reg[chk_addr_reg]
               && ({1'b0, bucket_gap} < limit_reg)
               && (!found_reg || (bucket_gap < best_dist_reg)
                   || ((bucket_gap == best_dist_reg) && (age > best_age_reg)));
    end

    assign pass_done = chk_valid_reg && (chk_addr_reg == LAST_ENTRY);
    assign emit_load = (state_reg == S_EMIT) && found_reg && out_free;
    assign fin_load  = (state_reg == S_FINISH) && out_free;
    assign do_arm    = id_ok_reg && (op_reg == OP_ARM);
    assign do_cancel = id_ok_reg && (op_reg == OP_CANCEL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            armed_reg        <= '0;
            insert_count_reg <= '0;
            last_time_reg    <= '0;
            issue_on_reg     <= 1'b0;
            issue_addr_reg   <= '0;
            chk_valid_reg    <= 1'b0;
            chk_addr_reg     <= '0;
            found_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit_load || fin_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            chk_valid_reg <= (state_reg == S_SCAN) && issue_on_reg;
            chk_addr_reg  <= issue_addr_reg;

            case (state_reg)
                S_IDLE:
                begin
                    if (item_accept)
                    begin
                        last_time_reg  <= now_time;
                        issue_on_reg   <= 1'b1;
                        issue_addr_reg <= '0;
                        found_reg      <= 1'b0;
                        state_reg      <= (limit_next != '0) ? S_SCAN : S_FINISH;
                    end
                end
                S_SCAN:
                begin
                    if (issue_on_reg)
                    begin
                        if (issue_addr_reg == LAST_ENTRY)
                        begin
                            issue_on_reg <= 1'b0;
                        end
                        else
                        begin
                            issue_addr_reg <= issue_addr_reg + 1'b1;
                        end
                    end
                    if (cand)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (pass_done)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (!found_reg)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else if (out_free)
                    begin
                        armed_reg[best_id_reg] <= 1'b0;
                        found_reg              <= 1'b0;
                        issue_on_reg           <= 1'b1;
                        issue_addr_reg         <= '0;
                        state_reg              <= S_SCAN;
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        if (do_arm)
                        begin
                            armed_reg[id_reg] <= 1'b1;
                            insert_count_reg  <= insert_count_reg + 1'b1;
                        end
                        else if (do_cancel)
                        begin
                            armed_reg[id_reg] <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            op_reg         <= opcode;
            id_reg         <= ENTRY_BITS'(entry_id);
            id_ok_reg      <= (int'(entry_id) < ENTRIES);
            arm_bucket_reg <= BUCKET_BITS'(now_time[BUCKET_BITS-1:0]
                                          + BUCKET_BITS'(timeout));
            base_reg       <= last_time_reg[BUCKET_BITS-1:0];
            limit_reg      <= limit_next;
        end
        if (cand)
        begin
            best_id_reg   <= chk_addr_reg;
            best_dist_reg <= bucket_gap;
            best_age_reg  <= age;
        end
        if (emit_load)
        begin
            kind_reg       <= KIND_EXPIRED;
            expired_id_reg <= ID_BITS'(best_id_reg);
            last_reg       <= 1'b0;
        end
        else if (fin_load)
        begin
            kind_reg       <= KIND_FINISHED;
            expired_id_reg <= '0;
            last_reg       <= 1'b1;
        end
    end

    assign result_valid = result_valid_reg;
    assign kind         = kind_reg;
    assign expired_id   = expired_id_reg;
    assign last         = last_reg;

    // The entry picked by a pass must still be armed when its expiry beat is loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_load |-> armed_reg[best_id_reg])
        else $error("expiring an entry that is not armed");

    // The stored time follows every accepted item.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_accept |=> (last_time_reg == $past(now_time)))
        else $error("last time not updated on accept");

    // Only the finished beat closes an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (kind == last))
        else $error("kind and last disagree");

    // Each completed arm stamps one new insertion number.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fin_load && do_arm) |=> (insert_count_reg == $past(insert_count_reg) + 1'b1))
        else $error("insert count not advanced on arm");

    // A new item is never taken while a pass is under way.
    assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> item_stall)
        else $error("item accepted during a scan");

endmodule
